FILE: design/lrt_pkg.sv
// ---------------------------------------------------------------------------
// lrt_pkg
// Shared types and constants for the learning reflector table: the entry
// layout held in each cell and the control word broadcast along the chain.
// ---------------------------------------------------------------------------
package lrt_pkg;

    localparam logic        OP_PACKET     = 1'b0;
    localparam logic        OP_TICK       = 1'b1;
    localparam logic [15:0] AGE_MAX       = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd10;

    typedef struct packed {
        logic [31:0] address;
        logic [15:0] port;
        logic [15:0] age;
    } entry_t;

    // Broadcast to every cell. shift moves each entry one cell toward the
    // head; push loads push_data at the tail of the valid run.
    typedef struct packed {
        logic        shift;
        logic        push;
        entry_t      push_data;
        logic [31:0] key_address;
        logic [15:0] key_port;
    } cell_ctrl_t;

endpackage

FILE: design/lrt_cell.sv
// ---------------------------------------------------------------------------
// lrt_cell
// One table slot. Holds an entry and its valid bit, compares it against the
// broadcast key, and shifts, holds or loads the pushed entry each cycle.
// ---------------------------------------------------------------------------
module lrt_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  lrt_pkg::cell_ctrl_t ctrl,
    input  lrt_pkg::entry_t    right_entry,
    input  logic               right_valid,
    input  logic               left_valid,
    output lrt_pkg::entry_t    entry,
    output logic               valid,
    output logic               match
);

    lrt_pkg::entry_t entry_reg, entry_next;
    logic            valid_reg, valid_next;

    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctrl.shift) begin
            entry_next = right_entry;
            valid_next = right_valid;
            // The last valid cell takes the pushed entry as the run moves up.
            if (ctrl.push && valid_reg && !right_valid) begin
                entry_next = ctrl.push_data;
                valid_next = 1'b1;
            end
        end else if (ctrl.push && !valid_reg && left_valid) begin
            entry_next = ctrl.push_data;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;
    assign match = valid_reg && (entry_reg.address == ctrl.key_address)
                   && (entry_reg.port == ctrl.key_port);

endmodule

FILE: design/learning_reflector_table_with_aging.sv
// A packet item passes through lookup and then one forward rotation of the cell chain before the
// next item is accepted; its results are registered, and when the sender is the oldest entry the
// first rotation step forwards nothing.
// A tick item sweeps the chain once; both rotate one entry per cycle unless stalled.
// A stalled result register holds the rotation until the result is taken.
// Reset empties the table and loads the timeout register with 10; entry contents are not cleared.
// ---------------------------------------------------------------------------
// learning_reflector_table_with_aging
// Endpoint table built as a chain of cells kept in insertion order. Packets
// look up and learn the sender, then rotate the chain once to forward to
// other entries; ticks rotate the chain once, aging and dropping entries.
// ---------------------------------------------------------------------------
module learning_reflector_table_with_aging #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [31:0] s_src_address,
    input  logic [15:0] s_src_port,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_dest_address,
    output logic [15:0] m_dest_port,
    output logic        m_last
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_LOOKUP, ST_FORWARD, ST_SWEEP} state_t;

    state_t              state_reg;
    logic [31:0]         key_address_reg;
    logic [15:0]         key_port_reg;
    logic [CNT_W-1:0]    count_reg, rot_reg, lim_reg, sent_reg, total_reg;
    logic [15:0]         timeout_reg;
    logic                out_valid_reg, out_last_reg;
    logic [31:0]         out_address_reg;
    logic [15:0]         out_port_reg;

    lrt_pkg::cell_ctrl_t ctrl;
    lrt_pkg::entry_t     cell_entry [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] cell_valid, cell_match;

    lrt_pkg::entry_t     head;
    logic                hit, full, head_match, emit_want, can_out, step;
    logic                keep, emit;
    logic [15:0]         aged;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            lrt_pkg::entry_t right_entry;
            logic            right_valid, left_valid;
            if (gi == TABLE_DEPTH - 1) begin : g_tail
                assign right_entry = '0;
                assign right_valid = 1'b0;
            end else begin : g_mid
                assign right_entry = cell_entry[gi+1];
                assign right_valid = cell_valid[gi+1];
            end
            if (gi == 0) begin : g_head
                assign left_valid = 1'b1;
            end else begin : g_body
                assign left_valid = cell_valid[gi-1];
            end
            lrt_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .right_entry (right_entry),
                .right_valid (right_valid),
                .left_valid  (left_valid),
                .entry       (cell_entry[gi]),
                .valid       (cell_valid[gi]),
                .match       (cell_match[gi])
            );
        end
    endgenerate

    assign head       = cell_entry[0];
    assign hit        = |cell_match;
    assign full       = (count_reg == CNT_W'(TABLE_DEPTH));
    assign head_match = (head.address == key_address_reg) && (head.port == key_port_reg);
    assign emit_want  = !head_match && (sent_reg != total_reg);
    assign can_out    = !out_valid_reg || m_ready;
    assign step       = !emit_want || can_out;
    assign emit       = (state_reg == ST_FORWARD) && (rot_reg != lim_reg) && step && emit_want;
    assign aged       = (head.age == lrt_pkg::AGE_MAX) ? head.age : head.age + 16'd1;
    assign keep       = (aged <= timeout_reg);

    always_comb begin
        ctrl             = '0;
        ctrl.key_address = key_address_reg;
        ctrl.key_port    = key_port_reg;
        ctrl.push_data   = head;
        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_LOOKUP: begin
                ctrl.push              = !hit && !full;
                ctrl.push_data.address = key_address_reg;
                ctrl.push_data.port    = key_port_reg;
                ctrl.push_data.age     = 16'd0;
            end
            ST_FORWARD: begin
                if (rot_reg != lim_reg && step) begin
                    ctrl.shift = 1'b1;
                    ctrl.push  = 1'b1;
                    if (head_match) begin
                        ctrl.push_data.age = 16'd0;
                    end
                end
            end
            ST_SWEEP: begin
                if (rot_reg != lim_reg) begin
                    ctrl.shift         = 1'b1;
                    ctrl.push          = keep;
                    ctrl.push_data.age = aged;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rot_reg       <= '0;
            lim_reg       <= '0;
            sent_reg      <= '0;
            total_reg     <= '0;
            timeout_reg   <= lrt_pkg::TIMEOUT_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        key_address_reg <= s_src_address;
                        key_port_reg    <= s_src_port;
                        rot_reg         <= '0;
                        sent_reg        <= '0;
                        lim_reg         <= count_reg;
                        state_reg       <= (s_opcode == lrt_pkg::OP_TICK) ? ST_SWEEP : ST_LOOKUP;
                    end
                end
                ST_LOOKUP: begin
                    // A full table with a new sender forwards to all but the newest entry.
                    total_reg <= (hit || full) ? count_reg - CNT_W'(1) : count_reg;
                    if (!hit && !full) begin
                        count_reg <= count_reg + CNT_W'(1);
                        lim_reg   <= count_reg + CNT_W'(1);
                    end
                    state_reg <= ST_FORWARD;
                end
                ST_FORWARD: begin
                    if (rot_reg == lim_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (step) begin
                        rot_reg <= rot_reg + CNT_W'(1);
                        if (emit_want) begin
                            out_address_reg <= head.address;
                            out_port_reg    <= head.port;
                            out_last_reg    <= (CNT_W'(sent_reg + CNT_W'(1)) == total_reg);
                            sent_reg        <= sent_reg + CNT_W'(1);
                        end
                    end
                end
                ST_SWEEP: begin
                    if (rot_reg == lim_reg) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        rot_reg <= rot_reg + CNT_W'(1);
                        if (!keep) begin
                            count_reg <= count_reg - CNT_W'(1);
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = out_valid_reg;
    assign m_dest_address = out_address_reg;
    assign m_dest_port    = out_port_reg;
    assign m_last         = out_last_reg;

    // The valid run in the chain always matches the entry count.
    a_count_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(cell_valid) == int'(count_reg))
        else $error("cell valid bits disagree with entry count");

    // Learning never stores a sender twice.
    a_unique_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cell_match))
        else $error("more than one cell matches the key");

    // Forwarding never emits more items than planned.
    a_sent_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FORWARD) |-> (sent_reg <= total_reg))
        else $error("forward count overran its total");

    // The last item of a packet leaves only once the planned count is reached.
    a_last_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(out_valid_reg) && out_last_reg && state_reg == ST_FORWARD)
        |-> (sent_reg == total_reg))
        else $error("last flag raised before the final destination");

endmodule

FILE: tb/sv/lrt_forward_checker.sv
// ---------------------------------------------------------------------------
// lrt_forward_checker
// Watches both channels and the timeout register port of the learning
// reflector table. It keeps its own copy of the endpoint table, works out
// the destinations that each packet item should be forwarded to, and
// compares every result item field by field against the oldest one due.
// ---------------------------------------------------------------------------
module lrt_forward_checker #(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_opcode,
    input  logic [31:0] s_src_address,
    input  logic [15:0] s_src_port,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_dest_address,
    input  logic [15:0] m_dest_port,
    input  logic        m_last,
    output int unsigned fail_count,
    output int unsigned dests_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] address;
        logic [15:0] port;
        logic        last;
    } dest_t;

    lrt_pkg::entry_t endpoints [DEPTH];
    int              fill_level;
    logic [15:0]     timeout_ticks;
    dest_t           dest_queue [$];

    initial begin
        fail_count    = 0;
        dests_pending = 0;
        fill_level    = 0;
        timeout_ticks = lrt_pkg::TIMEOUT_RESET;
    end

    // Look up the sender, learn it if there is room, and queue one destination per
    // other endpoint, at most DEPTH-1, in insertion order.
    function automatic void learn_and_forward(input logic [31:0] addr,
                                              input logic [15:0] port);
        bit    known;
        int    n;
        dest_t batch [DEPTH];
        known = 1'b0;
        n     = 0;
        for (int i = 0; i < fill_level; i++) begin
            if (!known && endpoints[i].address == addr && endpoints[i].port == port) begin
                endpoints[i].age = '0;
                known = 1'b1;
            end
        end
        if (!known && fill_level < DEPTH) begin
            endpoints[fill_level] = '{address: addr, port: port, age: 16'd0};
            fill_level++;
        end
        // With a full table and an unknown sender, only the oldest DEPTH-1
        // entries fit, so the newest one is left out.
        for (int i = 0; i < fill_level; i++) begin
            if (!(endpoints[i].address == addr && endpoints[i].port == port)
                && n < DEPTH - 1) begin
                batch[n] = '{address: endpoints[i].address, port: endpoints[i].port,
                             last: 1'b0};
                n++;
            end
        end
        if (n > 0) begin
            batch[n - 1].last = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            dest_queue = {dest_queue, batch[i]};
        end
    endfunction

    // One tick: every age goes up by one, saturating, and entries older than
    // the timeout drop out while the rest close ranks in order.
    function automatic void age_endpoints();
        int          wr;
        logic [16:0] aged;
        wr = 0;
        for (int rd = 0; rd < fill_level; rd++) begin
            aged = {1'b0, endpoints[rd].age};
            if (endpoints[rd].age != lrt_pkg::AGE_MAX) begin
                aged = aged + 17'd1;
            end
            if (aged <= {1'b0, timeout_ticks}) begin
                endpoints[wr]     = endpoints[rd];
                endpoints[wr].age = aged[15:0];
                wr++;
            end
        end
        fill_level = wr;
    endfunction

    always @(posedge aclk) begin : watch
        dest_t want;
        if (!aresetn) begin
            fill_level    = 0;
            timeout_ticks = lrt_pkg::TIMEOUT_RESET;
            dest_queue.delete();
        end else begin
            if (cfg_we) begin
                timeout_ticks = cfg_wdata;
            end
            // A result taken at this edge always belongs to an earlier item,
            // so it is checked before any new item is predicted.
            if (m_valid && m_ready) begin
                if (dest_queue.size() == 0) begin
                    $error("unexpected result item: dest_address %h dest_port %h last %b",
                           m_dest_address, m_dest_port, m_last);
                    fail_count++;
                end else begin
                    want = dest_queue.pop_front();
                    if (m_dest_address !== want.address) begin
                        $error("dest_address: expected %h, actual %h",
                               want.address, m_dest_address);
                        fail_count++;
                    end
                    if (m_dest_port !== want.port) begin
                        $error("dest_port: expected %h, actual %h", want.port, m_dest_port);
                        fail_count++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %b, actual %b", want.last, m_last);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_opcode == lrt_pkg::OP_TICK) begin
                    age_endpoints();
                end else begin
                    learn_and_forward(s_src_address, s_src_port);
                end
            end
        end
        dests_pending = dest_queue.size();
    end

endmodule

FILE: tb/sv/learning_reflector_table_with_aging_tb.sv
// ---------------------------------------------------------------------------
// learning_reflector_table_with_aging_tb
// Drives packet and tick items into the endpoint table, first a directed
// sequence that fills the table and overflows it, then random phases under
// a range of timeout settings. Both channels idle at random, the receiver
// stalls once for a long stretch, and a separate checker predicts and
// compares every forwarded destination.
// ---------------------------------------------------------------------------
module learning_reflector_table_with_aging_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 40;
    localparam int HOLD_CYCLES = 300;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        cfg_we         = 1'b0;
    logic [15:0] cfg_wdata      = '0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic        s_opcode       = lrt_pkg::OP_PACKET;
    logic [31:0] s_src_address  = '0;
    logic [15:0] s_src_port     = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [31:0] m_dest_address;
    logic [15:0] m_dest_port;
    logic        m_last;

    int unsigned fail_count;
    int unsigned dests_pending;
    int          cycle_count;
    int          phase_no = 0;
    bit          steady   = 1'b0;
    bit          held     = 1'b0;

    always #10 aclk = ~aclk;

    learning_reflector_table_with_aging #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_src_address (s_src_address),
        .s_src_port    (s_src_port),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_dest_address(m_dest_address),
        .m_dest_port   (m_dest_port),
        .m_last        (m_last)
    );

    lrt_forward_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_src_address (s_src_address),
        .s_src_port    (s_src_port),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_dest_address(m_dest_address),
        .m_dest_port   (m_dest_port),
        .m_last        (m_last),
        .fail_count    (fail_count),
        .dests_pending (dests_pending)
    );

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: random back-pressure, except for one long hold-off while the
    // sender keeps the table busy, and a stretch with no stalls at all.
    initial begin
        forever begin
            if (phase_no == 1 && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) begin
                    @(posedge aclk);
                end
            end else if (steady) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 15);
                @(posedge aclk);
            end
        end
    end

    task automatic send_item(input logic op, input logic [31:0] addr,
                             input logic [15:0] port);
        if (!steady && $urandom_range(0, 99) < 15) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= op;
        s_src_address <= addr;
        s_src_port    <= port;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    // Stop offering items, let every due destination arrive, then give a
    // tick or a silent packet time to finish its rotation.
    task automatic wait_idle();
        s_valid <= 1'b0;
        do begin
            @(negedge aclk);
        end while (dests_pending != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input int idx, input logic [15:0] timeout, input int n_items);
        logic [31:0] pool_addr [24];
        logic [15:0] pool_port [24];
        int          pool_size;
        int          roll;
        int          k;
        wait_idle();
        write_timeout(timeout);
        phase_no  = idx;
        steady    = (idx == 4);
        // Neighbors in the pool sometimes share an address or a port, so that
        // a match on only one of the two is exercised.
        pool_size = $urandom_range(3, 24);
        for (int i = 0; i < pool_size; i++) begin
            roll         = $urandom_range(0, 99);
            pool_addr[i] = $urandom;
            pool_port[i] = 16'($urandom_range(0, 65535));
            if (i > 0 && roll < 20) begin
                pool_addr[i] = pool_addr[i - 1];
            end else if (i > 0 && roll < 40) begin
                pool_port[i] = pool_port[i - 1];
            end
        end
        repeat (n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                send_item(lrt_pkg::OP_TICK, $urandom, 16'($urandom_range(0, 65535)));
            end else if (roll < 20) begin
                send_item(lrt_pkg::OP_PACKET, $urandom, 16'($urandom_range(0, 65535)));
            end else begin
                k = $urandom_range(0, pool_size - 1);
                send_item(lrt_pkg::OP_PACKET, pool_addr[k], pool_port[k]);
            end
        end
    endtask

    initial begin
        logic [31:0] newest_addr;
        logic [15:0] newest_port;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset timeout. A lone sender gets nothing
        // back, a tick ignores its address fields, and the table is filled
        // and then offered one sender more than it holds.
        send_item(lrt_pkg::OP_PACKET, 32'h0000_0000, 16'h0000);
        send_item(lrt_pkg::OP_PACKET, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(lrt_pkg::OP_PACKET, 32'h0000_0000, 16'h0000);
        send_item(lrt_pkg::OP_TICK,   32'hFFFF_FFFF, 16'hFFFF);
        send_item(lrt_pkg::OP_PACKET, 32'h0000_0000, 16'hFFFF);
        send_item(lrt_pkg::OP_PACKET, 32'hFFFF_FFFF, 16'h0000);
        newest_addr = '0;
        newest_port = '0;
        for (int i = 0; i < DEPTH - 4; i++) begin
            newest_addr = $urandom;
            newest_port = 16'($urandom_range(0, 65535));
            send_item(lrt_pkg::OP_PACKET, newest_addr, newest_port);
        end
        send_item(lrt_pkg::OP_PACKET, 32'h1234_5678, 16'h9ABC);
        send_item(lrt_pkg::OP_PACKET, newest_addr, newest_port);
        send_item(lrt_pkg::OP_TICK, 32'h0000_0000, 16'h0000);

        run_phase(1, 16'hFFFF, 50);
        run_phase(2, 16'd0, 50);
        run_phase(3, 16'd1, 50);
        run_phase(4, 16'd3, 50);
        run_phase(5, 16'hFFFE, 50);
        run_phase(6, 16'd2, 50);
        run_phase(7, 16'($urandom_range(4, 30)), 50);
        run_phase(8, lrt_pkg::TIMEOUT_RESET, 50);

        wait_idle();
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
